>>> rtl/dss_pkg.sv
// Shared types and constants for the deduplicating seen-set filter.
// Used by the channel interfaces, the slot cells, the controller and the top level.
package dss_pkg;

	localparam int OFFSET_W = 47;
	localparam int INDEX_W = 16;
	localparam int KEY_W = OFFSET_W + INDEX_W;
	localparam int LIMIT_W = 13;
	localparam int HOME_OFS_LSB = 32 - INDEX_W;

	localparam int TABLE_SLOTS_DEF = 256;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);
	localparam logic [LIMIT_W-1:0] COUNT_MAX = {LIMIT_W{1'b1}};

	localparam logic OP_CLAIM = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic stop;
	} cell_ctl_t;

	typedef struct packed {
		logic hit;
		logic placed;
	} probe_stat_t;

endpackage

>>> rtl/dss_query_if.sv
// Input channel of the seen-set filter: one claim or clear item per handshake.
// Depends on dss_pkg for the field widths.
interface dss_query_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [dss_pkg::OFFSET_W-1:0] caller_offset;
	logic [dss_pkg::INDEX_W-1:0]  objective_index;

	modport source (output valid, output operation, output caller_offset,
		output objective_index, input ready);
	modport sink (input valid, input operation, input caller_offset,
		input objective_index, output ready);
endinterface

>>> rtl/dss_result_if.sv
// Output channel of the seen-set filter: one verdict item per handshake.
// Depends on dss_pkg for the field widths.
interface dss_result_if;
	logic                        valid;
	logic                        ready;
	logic                        is_new;
	logic                        table_full;
	logic [dss_pkg::LIMIT_W-1:0] sequence_res;
	logic                        report_allowed;

	modport source (output valid, output is_new, output table_full,
		output sequence_res, output report_allowed, input ready);
	modport sink (input valid, input is_new, input table_full,
		input sequence_res, input report_allowed, output ready);
endinterface

>>> rtl/dss_cfg_if.sv
// Configuration write channel of the seen-set filter, carrying the report limit.
// Depends on dss_pkg for the register width.
interface dss_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [dss_pkg::LIMIT_W-1:0] report_limit;

	modport source (output valid, output report_limit, input ready);
	modport sink (input valid, input report_limit, output ready);
endinterface

>>> rtl/dss_cell.sv
// One slot of the hash table: stored key, occupied flag and the probe token stage.
// Depends on dss_pkg for the key width and the control structs.
module dss_cell #(
	parameter int SLOT_W = 8,
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dss_pkg::cell_ctl_t        ctl,
	input  logic [SLOT_W-1:0]         home,
	input  logic [dss_pkg::KEY_W-1:0] key,
	input  logic                      tok_in,
	output logic                      tok_out,
	output logic                      hit,
	output logic                      placed
);

	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

	logic                      tok_q;
	logic                      valid_q;
	logic [dss_pkg::KEY_W-1:0] key_q;
	logic                      same;

	assign same    = (key_q == key);
	assign hit     = tok_q && valid_q && same;
	assign placed  = tok_q && !valid_q;
	assign tok_out = tok_q && valid_q && !same;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (ctl.clear || ctl.stop) begin
				tok_q <= 1'b0;
			end else if (ctl.start) begin
				tok_q <= (home == MY_SLOT);
			end else begin
				tok_q <= tok_in;
			end
			if (ctl.clear) begin
				valid_q <= 1'b0;
			end else if (placed) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (placed) begin
			key_q <= key;
		end
	end

endmodule

>>> rtl/dss_ctrl.sv
// Controller: handshakes, probe sequencing, sequence counter and output register.
// Depends on dss_pkg and the three channel interfaces.
module dss_ctrl #(
	parameter int SLOT_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	dss_cfg_if.sink                   cfg,
	dss_query_if.sink                 query,
	dss_result_if.source              result,
	input  dss_pkg::probe_stat_t      stat,
	output dss_pkg::cell_ctl_t        ctl,
	output logic [SLOT_W-1:0]         home,
	output logic [dss_pkg::KEY_W-1:0] key
);

	dss_pkg::state_t state_q, state_d;

	logic [SLOT_W-1:0]                probe_q;
	logic [dss_pkg::LIMIT_W-1:0]      cnt_q;
	logic [dss_pkg::LIMIT_W-1:0]      limit_q;
	logic [dss_pkg::KEY_W-1:0]        key_q;

	logic                             res_new_q;
	logic                             res_full_q;
	logic [dss_pkg::LIMIT_W-1:0]      res_seq_q;
	logic                             res_rep_q;

	logic                             out_valid_q;
	logic                             out_new_q;
	logic                             out_full_q;
	logic [dss_pkg::LIMIT_W-1:0]      out_seq_q;
	logic                             out_rep_q;

	logic                             accept;
	logic                             finish;
	logic                             load;
	logic [dss_pkg::LIMIT_W-1:0]      cap;
	logic [dss_pkg::LIMIT_W-1:0]      cnt_nxt;

	assign cfg.ready             = 1'b1;
	assign key                   = key_q;
	assign result.valid          = out_valid_q;
	assign result.is_new         = out_new_q;
	assign result.table_full     = out_full_q;
	assign result.sequence_res   = out_seq_q;
	assign result.report_allowed = out_rep_q;

	always_comb begin
		query.ready = (state_q == dss_pkg::ST_IDLE);
		accept      = query.valid && query.ready;
		finish      = (state_q == dss_pkg::ST_PROBE) &&
			(stat.hit || stat.placed || (&probe_q));
		load        = (state_q == dss_pkg::ST_HOLD) && (!out_valid_q || result.ready);
		ctl.start   = accept && (query.operation == dss_pkg::OP_CLAIM);
		ctl.clear   = accept && (query.operation == dss_pkg::OP_CLEAR);
		ctl.stop    = finish;
		home        = query.objective_index[SLOT_W-1:0] ^
			query.caller_offset[dss_pkg::HOME_OFS_LSB +: SLOT_W];
		cap         = (limit_q == dss_pkg::COUNT_MAX) ? dss_pkg::COUNT_MAX :
			limit_q + dss_pkg::LIMIT_W'(1);
		cnt_nxt     = (cnt_q < cap) ? cnt_q + dss_pkg::LIMIT_W'(1) : cnt_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dss_pkg::ST_IDLE: begin
				if (ctl.start) begin
					state_d = dss_pkg::ST_PROBE;
				end else if (ctl.clear) begin
					state_d = dss_pkg::ST_HOLD;
				end
			end
			dss_pkg::ST_PROBE: begin
				if (finish) begin
					state_d = dss_pkg::ST_HOLD;
				end
			end
			dss_pkg::ST_HOLD: begin
				if (load) begin
					state_d = dss_pkg::ST_IDLE;
				end
			end
			default: state_d = dss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dss_pkg::ST_IDLE;
			probe_q     <= '0;
			cnt_q       <= '0;
			limit_q     <= dss_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.report_limit;
			end
			if (ctl.start) begin
				probe_q <= '0;
			end else if (state_q == dss_pkg::ST_PROBE) begin
				probe_q <= probe_q + SLOT_W'(1);
			end
			if (ctl.clear) begin
				cnt_q <= '0;
			end else if (finish && stat.placed) begin
				cnt_q <= cnt_nxt;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			key_q <= {query.caller_offset, query.objective_index};
		end
		if (ctl.clear) begin
			res_new_q  <= 1'b0;
			res_full_q <= 1'b0;
			res_seq_q  <= '0;
			res_rep_q  <= 1'b0;
		end else if (finish) begin
			res_new_q  <= stat.placed;
			res_full_q <= !stat.hit && !stat.placed;
			res_seq_q  <= stat.placed ? cnt_nxt : '0;
			res_rep_q  <= stat.placed && (cnt_nxt <= limit_q);
		end
		if (load) begin
			out_new_q  <= res_new_q;
			out_full_q <= res_full_q;
			out_seq_q  <= res_seq_q;
			out_rep_q  <= res_rep_q;
		end
	end

endmodule

>>> rtl/dedup_seen_set_filter.sv
// Top level of the deduplicating seen-set filter: a ring of slot cells and its controller.
// Depends on dss_pkg, the channel interfaces, dss_cell and dss_ctrl.
//
//   channel  role    handshake      payload
//   cfg      sink    valid/ready    report_limit
//   query    sink    valid/ready    operation, caller_offset, objective_index
//   result   source  valid/ready    is_new, table_full, sequence_res, report_allowed
//
// A claim is probed over P cells, where P is the probe length (1 to TABLE_SLOTS): the probe
// token moves one cell around the ring each cycle; the verdict then passes through ST_HOLD.
// A clear goes straight to ST_HOLD; all slots are emptied in the cycle it is accepted.
// One item is probed at a time; while a result waits, the next item may finish its probe,
// and further items are held back.
// Reset empties the table at once, zeroes the counter and sets the report limit to 256.
// TABLE_SLOTS must be a power of two.
module dedup_seen_set_filter #(
	parameter int TABLE_SLOTS = dss_pkg::TABLE_SLOTS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	dss_cfg_if.sink      cfg,
	dss_query_if.sink    query,
	dss_result_if.source result
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);

	dss_pkg::cell_ctl_t        ctl;
	dss_pkg::probe_stat_t      stat;
	logic [SLOT_W-1:0]         home;
	logic [dss_pkg::KEY_W-1:0] key;
	logic [TABLE_SLOTS-1:0]    tok;
	logic [TABLE_SLOTS-1:0]    hit;
	logic [TABLE_SLOTS-1:0]    placed;

	assign stat.hit    = |hit;
	assign stat.placed = |placed;

	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		localparam int PREV = (i == 0) ? TABLE_SLOTS - 1 : i - 1;

		dss_cell #(
			.SLOT_W (SLOT_W),
			.IDX    (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.home    (home),
			.key     (key),
			.tok_in  (tok[PREV]),
			.tok_out (tok[i]),
			.hit     (hit[i]),
			.placed  (placed[i])
		);
	end

	dss_ctrl #(
		.SLOT_W (SLOT_W)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.query  (query),
		.result (result),
		.stat   (stat),
		.ctl    (ctl),
		.home   (home),
		.key    (key)
	);

endmodule
